// File: hw/rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian cross sharpen package
// Shared constants for the streaming 3x3 cross sharpening filter.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int PIX_W       = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int SUM_W        = 12;
   localparam int RES_SLOTS    = 3;
   localparam int CNT_W        = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

endpackage

// File: hw/rtl/laplacian_sharpen_cross.sv
// A pixel is registered in stage A, and its results are loaded into the result slots
// when it advances. One pixel per cycle while each pixel yields at most one result and
// the output is not stalled; a pixel yielding two or three results holds stage A until
// its earlier results are taken. The line store is read at acceptance into a register.
// Reset (synchronous, active high) clears counters, window and pipeline valids;
// line store contents are kept and are undefined until first written.
// ----------------------------------------------------------------------------
// Laplacian cross sharpen
// Streams raster pixels through two line stores and a small window, and emits
// 5*centre minus the four neighbours, clamped, with border pixels passed on.
// ----------------------------------------------------------------------------
module laplacian_sharpen_cross
   import lsc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [PIX_W-1:0]               req_pixel_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [PIX_W-1:0]               rsp_pixel_out,
   output logic [$clog2(MAX_HEIGHT)-1:0]  rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]   rsp_out_col,
   output logic                           rsp_last_of_item,
   output logic                           rsp_end_of_frame
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [RW-1:0]    row;
      logic [CW-1:0]    col;
      logic             last;
      logic             eof;
   } result_type;

   // ---------------- configuration ----------------
   logic [CFG_WIDTH_W-1:0]  cfg_width_ff, cfg_width_in;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff, cfg_height_in;
   logic                    cfg_hit;
   logic [CW:0]             w_eff;
   logic [RW:0]             h_eff;
   logic [CW-1:0]           w_last;
   logic [RW-1:0]           h_last;

   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_hit       = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               cfg_width_in = csr_wr_data[CFG_WIDTH_W-1:0];
               cfg_hit      = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               cfg_height_in = csr_wr_data[CFG_HEIGHT_W-1:0];
               cfg_hit       = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW+1)'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = (RW+1)'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         h_eff = (RW+1)'(MAX_HEIGHT);
      end else begin
         h_eff = (RW+1)'(cfg_height_ff);
      end
      w_last = CW'(w_eff - 1'b1);
      h_last = RW'(h_eff - 1'b1);
   end

   // ---------------- handshake control ----------------
   logic                 a_valid_ff, a_valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 accept, advance, pop;

   assign pop       = (cnt_ff != '0) && !rsp_stall;
   assign advance   = a_valid_ff && ((cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && pop));
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // ---------------- position counters ----------------
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : RW'(row_ff + 1'b1);
         end else begin
            col_in = CW'(col_ff + 1'b1);
         end
      end
   end

   // ---------------- stage A: input register and line store read ----------------
   logic [PIX_W-1:0]   a_pix_ff, a_pix_in;
   logic [CW-1:0]      a_col_ff, a_col_in;
   logic [RW-1:0]      a_row_ff, a_row_in;
   logic               a_col_last_ff, a_col_last_in;
   logic               a_row_last_ff, a_row_last_in;

   // Each word holds {row above the previous one, previous row} for one column.
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] line_rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff, fwd_data_in;
   logic               fwd_ff, fwd_in;
   logic [2*PIX_W-1:0] line_word;
   logic [2*PIX_W-1:0] line_wr;

   always_comb begin
      a_valid_in    = a_valid_ff;
      a_pix_in      = a_pix_ff;
      a_col_in      = a_col_ff;
      a_row_in      = a_row_ff;
      a_col_last_in = a_col_last_ff;
      a_row_last_in = a_row_last_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      if (advance) begin
         a_valid_in = 1'b0;
      end
      if (accept) begin
         a_valid_in    = 1'b1;
         a_pix_in      = req_pixel_in;
         a_col_in      = col_ff;
         a_row_in      = row_ff;
         a_col_last_in = (col_ff == w_last);
         a_row_last_in = (row_ff == h_last);
         // The outgoing transaction writes this very column in the same cycle,
         // so the memory would return the old word; keep the new one instead.
         fwd_in        = advance && (a_col_ff == col_ff);
         fwd_data_in   = line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (advance) begin
         line_mem[a_col_ff] <= line_wr;
      end
   end

   assign line_word = fwd_ff ? fwd_data_ff : line_rd_ff;

   // ---------------- window and kernel ----------------
   logic [PIX_W-1:0] top_px, mid_px;
   logic [PIX_W-1:0] win_top_ff, win_top_in;
   logic [PIX_W-1:0] win_mid_ff, win_mid_in;
   logic [PIX_W-1:0] win_pix_ff, win_pix_in;
   logic [PIX_W-1:0] win_mid_old_ff, win_mid_old_in;
   logic [SUM_W-1:0] pos_sum, neg_sum, diff;
   logic [PIX_W-1:0] sharp_px;

   assign top_px  = line_word[2*PIX_W-1:PIX_W];
   assign mid_px  = line_word[PIX_W-1:0];
   assign line_wr = {mid_px, a_pix_ff};

   always_comb begin
      win_top_in     = win_top_ff;
      win_mid_in     = win_mid_ff;
      win_pix_in     = win_pix_ff;
      win_mid_old_in = win_mid_old_ff;
      if (cfg_hit) begin
         win_top_in     = '0;
         win_mid_in     = '0;
         win_pix_in     = '0;
         win_mid_old_in = '0;
      end else if (advance) begin
         win_top_in     = top_px;
         win_mid_in     = mid_px;
         win_pix_in     = a_pix_ff;
         win_mid_old_in = win_mid_ff;
      end
   end

   always_comb begin
      pos_sum = (SUM_W'(win_mid_ff) << 2) + SUM_W'(win_mid_ff);
      neg_sum = SUM_W'(win_mid_old_ff) + SUM_W'(mid_px) + SUM_W'(win_top_ff)
              + SUM_W'(win_pix_ff);
      diff    = pos_sum - neg_sum;
      if (diff[SUM_W-1]) begin
         sharp_px = '0;
      end else if (diff > SUM_W'(PIX_MAX)) begin
         sharp_px = PIX_MAX;
      end else begin
         sharp_px = diff[PIX_W-1:0];
      end
   end

   // ---------------- result building ----------------
   logic       e1_v, e2_v, e3_v;
   logic       border;
   result_type e1, e2, e3;
   result_type slot0, slot1;
   result_type res_ff [RES_SLOTS];
   result_type res_in [RES_SLOTS];

   always_comb begin
      e1_v   = (a_row_ff != '0) && (a_col_ff != '0);
      e2_v   = (a_row_ff != '0) && a_col_last_ff;
      e3_v   = a_row_last_ff;
      // The pixel one row up and one column left is a border pixel when it
      // sits in the top row or the first column. The last column of a row is
      // passed on separately and never reaches this path.
      border = (a_row_ff == RW'(1)) || (a_col_ff == CW'(1));

      e1.pixel = border ? win_mid_ff : sharp_px;
      e1.row   = RW'(a_row_ff - 1'b1);
      e1.col   = CW'(a_col_ff - 1'b1);
      e1.last  = !e2_v && !e3_v;
      e1.eof   = 1'b0;

      e2.pixel = mid_px;
      e2.row   = RW'(a_row_ff - 1'b1);
      e2.col   = a_col_ff;
      e2.last  = !e3_v;
      e2.eof   = 1'b0;

      e3.pixel = a_pix_ff;
      e3.row   = a_row_ff;
      e3.col   = a_col_ff;
      e3.last  = 1'b1;
      e3.eof   = a_col_last_ff;

      slot0 = e1_v ? e1 : (e2_v ? e2 : e3);
      slot1 = e1_v ? (e2_v ? e2 : e3) : e3;
   end

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (advance) begin
         res_in[0] = slot0;
         res_in[1] = slot1;
         res_in[2] = e3;
         cnt_in    = CNT_W'(e1_v) + CNT_W'(e2_v) + CNT_W'(e3_v);
      end else if (pop) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         cnt_in    = CNT_W'(cnt_ff - 1'b1);
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff   <= RESET_FRAME_WIDTH;
         cfg_height_ff  <= RESET_FRAME_HEIGHT;
         col_ff         <= '0;
         row_ff         <= '0;
         a_valid_ff     <= 1'b0;
         cnt_ff         <= '0;
         fwd_ff         <= 1'b0;
         win_top_ff     <= '0;
         win_mid_ff     <= '0;
         win_pix_ff     <= '0;
         win_mid_old_ff <= '0;
      end else begin
         cfg_width_ff   <= cfg_width_in;
         cfg_height_ff  <= cfg_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         a_valid_ff     <= a_valid_in;
         cnt_ff         <= cnt_in;
         fwd_ff         <= fwd_in;
         win_top_ff     <= win_top_in;
         win_mid_ff     <= win_mid_in;
         win_pix_ff     <= win_pix_in;
         win_mid_old_ff <= win_mid_old_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff      <= a_pix_in;
      a_col_ff      <= a_col_in;
      a_row_ff      <= a_row_in;
      a_col_last_ff <= a_col_last_in;
      a_row_last_ff <= a_row_last_in;
      fwd_data_ff   <= fwd_data_in;
      res_ff        <= res_in;
   end

   // ---------------- outputs ----------------
   assign rsp_valid        = (cnt_ff != '0);
   assign rsp_pixel_out    = res_ff[0].pixel;
   assign rsp_out_row      = res_ff[0].row;
   assign rsp_out_col      = res_ff[0].col;
   assign rsp_last_of_item = res_ff[0].last;
   assign rsp_end_of_frame = res_ff[0].eof;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Laplacian cross sharpen testbench
// Streams raster frames of several sizes through the filter. A predictor keeps
// its own line stores, window and counters and queues the expected results of
// each accepted pixel. A monitor compares every returned result with them.
// ----------------------------------------------------------------------------
module tb
   import lsc_pkg::*;
();

   localparam int ROW_W         = $clog2(DEF_MAX_HEIGHT);
   localparam int COL_W         = $clog2(DEF_MAX_WIDTH);
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;

   // Indexes past the end of the register map; writes to them are dropped.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
      logic             eof;
   } out_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic [ROW_W-1:0]       rsp_out_row;
   logic [COL_W-1:0]       rsp_out_col;
   logic                   rsp_last_of_item;
   logic                   rsp_end_of_frame;

   // Predictor state.
   out_pixel_type           sharpened_q[$];
   logic [PIX_W-1:0]        line_above[DEF_MAX_WIDTH];
   logic [PIX_W-1:0]        line_two_above[DEF_MAX_WIDTH];
   logic [PIX_W-1:0]        window[6];
   int                      col_pos;
   int                      row_pos;
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;

   int error_count  = 0;
   int quiet_cycles = 0;
   bit gaps_on      = 1'b1;
   bit stall_on     = 1'b1;

   laplacian_sharpen_cross u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 6; i++) window[i] = '0;
   endfunction

   // Works out the results caused by one accepted pixel and advances the state.
   function automatic void predict_sharpen(input logic [PIX_W-1:0] pix);
      int               w;
      int               h;
      int               r;
      int               c;
      int               n;
      int               s;
      logic [PIX_W-1:0] up_px;
      logic [PIX_W-1:0] mid_px;
      logic [PIX_W-1:0] centre_val;
      out_pixel_type    res[3];
      w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      h = (height_reg == 0) ? 1 :
          (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      up_px  = line_two_above[c];
      mid_px = line_above[c];
      n = 0;
      // The window centre is the pixel one row up and one column left.
      if (r >= 1 && c >= 1) begin
         if (r == 1 || c == 1 || c >= w) begin
            centre_val = window[4];
         end else begin
            s = 5 * int'(window[4]) - int'(window[1]) - int'(mid_px)
                - int'(window[3]) - int'(window[5]);
            if (s < 0) s = 0;
            if (s > int'(PIX_MAX)) s = int'(PIX_MAX);
            centre_val = PIX_W'(s);
         end
         res[n] = '{centre_val, ROW_W'(r - 1), COL_W'(c - 1), 1'b0, 1'b0};
         n++;
      end
      // The last column of the row above has no right neighbour to wait for.
      if (r >= 1 && c + 1 == w) begin
         res[n] = '{mid_px, ROW_W'(r - 1), COL_W'(c), 1'b0, 1'b0};
         n++;
      end
      if (r + 1 == h) begin
         res[n] = '{pix, ROW_W'(r), COL_W'(c), 1'b0, (c + 1 == w)};
         n++;
      end
      if (n > 0) res[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) sharpened_q.push_back(res[i]);

      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = up_px;
      window[4] = mid_px;
      window[5] = pix;
      line_two_above[c] = mid_px;
      line_above[c]     = pix;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Checks results, tracks register writes and predicts on each accepted pixel.
   always @(posedge clock) begin
      out_pixel_type want;
      if (reset) begin
         width_reg  = RESET_FRAME_WIDTH;
         height_reg = RESET_FRAME_HEIGHT;
         for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
         end
         restart_frame();
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sharpened_q.size() == 0) begin
               $error("unexpected result: pixel %0d at row %0d, column %0d",
                      rsp_pixel_out, rsp_out_row, rsp_out_col);
               error_count++;
            end else begin
               want = sharpened_q.pop_front();
               check_field("pixel_out", want.pixel, rsp_pixel_out);
               check_field("out_row", want.row, rsp_out_row);
               check_field("out_col", want.col, rsp_out_col);
               check_field("last_of_item", want.last, rsp_last_of_item);
               check_field("end_of_frame", want.eof, rsp_end_of_frame);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_reg = csr_wr_data[CFG_WIDTH_W-1:0];
                  restart_frame();
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_wr_data[CFG_HEIGHT_W-1:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_sharpen(req_pixel_in);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("laplacian_sharpen_cross regression: fail");
      $finish;
   end

   // Output back-pressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9)) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops the stream and lets the block empty before anything is reconfigured.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sharpened_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure_frame(input int w, input int h);
      drain_results();
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return PIX_MAX;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // One interior pixel that clamps high, surrounded by border pass-through.
   task automatic test_border_and_clamp();
      logic [PIX_W-1:0] frame[9];
      frame = '{8'd10, 8'd0, 8'd77, 8'd200, 8'd255, 8'd3, 8'd128, 8'd1, 8'd255};
      configure_frame(3, 3);
      foreach (frame[i]) send_pixel(frame[i]);
   endtask

   // Zero sizes act as one, oversized values saturate at the maximum.
   task automatic test_degenerate_sizes();
      configure_frame(0, 0);
      send_pixel(8'hA5);
      send_pixel(8'h5A);
      configure_frame(13'h1FFF, 1);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      configure_frame(1, 13'h1FFF);
      send_pixel(8'h3C);
      send_pixel(8'hC3);
   endtask

   // Spare indexes leave the frame alone; a real write restarts it mid-row.
   task automatic test_restart_and_spare_index();
      configure_frame(3, 2);
      repeat (4) send_pixel(random_pixel());
      drain_results();
      write_reg(REG_SPARE_2, 13'h1FFF);
      write_reg(REG_SPARE_3, 13'h0001);
      repeat (2) send_pixel(random_pixel());
      send_pixel(random_pixel());
      drain_results();
      write_reg(REG_FRAME_WIDTH, 13'd2);
      repeat (4) send_pixel(random_pixel());
   endtask

   // Mostly whole frames of small sizes, some back to back and some cut short.
   task automatic test_random_frames(input int target, input bit idling);
      int sent;
      int w;
      int h;
      int total;
      int n;
      bit whole;
      sent     = 0;
      whole    = 1'b0;
      w        = 1;
      h        = 1;
      gaps_on  = idling;
      stall_on = idling;
      while (sent < target) begin
         if (!whole || $urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               w = $urandom_range(9, DEF_MAX_WIDTH);
               h = $urandom_range(1, 2);
            end else begin
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 6);
            end
            configure_frame(w, h);
         end
         total = w * h;
         if (total > 40 || $urandom_range(0, 7) == 0)
            n = $urandom_range(1, (total < 40) ? total : 40);
         else
            n = total;
         whole = (n == total);
         repeat (n) send_pixel(random_pixel());
         sent += n;
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = REG_FRAME_WIDTH;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_pixel_in = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_border_and_clamp();
      test_degenerate_sizes();
      test_restart_and_spare_index();
      test_random_frames(270, 1'b1);
      test_random_frames(80, 1'b0);
      drain_results();

      if (error_count == 0) $display("laplacian_sharpen_cross regression: pass");
      else $display("laplacian_sharpen_cross regression: fail");
      $finish;
   end

endmodule
